### src/lcoa_pkg.sv
// ----------------------------------------------------------------------------
// lcoa_pkg
// Shared types and codes for the lamp command override arbiter.
// ----------------------------------------------------------------------------
package lcoa_pkg;

   // event kinds
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_FULL   = 2'd1;
   localparam logic [1:0] MODE_LEGACY = 2'd2;
   localparam logic [1:0] MODE_PEER   = 2'd3;

   // result codes
   localparam logic [2:0] RES_TICK     = 3'd0;
   localparam logic [2:0] RES_CMD_OK   = 3'd1;
   localparam logic [2:0] RES_CMD_REJ  = 3'd2;
   localparam logic [2:0] RES_PEER_OK  = 3'd3;
   localparam logic [2:0] RES_PEER_REJ = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_HOST_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_PEER_TIMEOUT  = 2'd1;
   localparam logic [1:0] CSR_STATUS_PERIOD = 2'd2;

   localparam logic [15:0] HOST_TIMEOUT_RESET  = 16'd500;
   localparam logic [15:0] PEER_TIMEOUT_RESET  = 16'd500;
   localparam logic [15:0] STATUS_PERIOD_RESET = 16'd100;

   // override flag bits
   localparam int OVR_TURN_BIT   = 0;
   localparam int OVR_BRAKE_BIT  = 1;
   localparam int OVR_WINDOW_BIT = 2;

   localparam logic [1:0] TURN_OFF   = 2'd0;
   localparam logic [1:0] TURN_LEFT  = 2'd1;
   localparam logic [1:0] TURN_RIGHT = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] now_ms;
      logic        packet_ok;
      logic [7:0]  override_byte;
      logic [7:0]  turn_or_left_byte;
      logic [7:0]  right_byte;
      logic [7:0]  brake_byte;
      logic [7:0]  window_byte;
      logic [15:0] sequence_number;
      logic        bus_off;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_result;
      logic        led_left;
      logic        led_right;
      logic        led_brake;
      logic        window_drive;
      logic        status_valid;
      logic [15:0] status_sequence;
      logic [1:0]  status_turn;
      logic        status_brake;
      logic [3:0]  status_sources;
      logic        status_bus_off;
      logic        status_window;
   } rsp_type;

endpackage

### src/lcoa_in_stage.sv
// ----------------------------------------------------------------------------
// lcoa_in_stage
// Input register: holds one request until the arbiter core takes it.
// ----------------------------------------------------------------------------
module lcoa_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lcoa_pkg::req_type req_data,
   input  logic             advance,
   output logic             held_valid,
   output lcoa_pkg::req_type held_data
);

   logic             valid_ff;
   logic             valid_in;
   lcoa_pkg::req_type data_ff;
   logic             load;

   assign req_stall = valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;
   assign valid_in  = load | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

### src/lcoa_core.sv
// ----------------------------------------------------------------------------
// lcoa_core
// Link state, watchdogs and source selection; one request per advance.
// ----------------------------------------------------------------------------
module lcoa_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   input  logic             advance,
   input  lcoa_pkg::req_type req,
   output lcoa_pkg::rsp_type rsp
);

   logic [15:0] host_timeout_ff, peer_timeout_ff, status_period_ff;

   logic [1:0]  peer_turn_ff, peer_turn_in;
   logic        peer_brake_ff, peer_brake_in;
   logic [15:0] peer_sequence_ff, peer_sequence_in;
   logic [31:0] peer_last_rx_ff, peer_last_rx_in;
   logic        peer_alive_ff, peer_alive_in;
   logic [2:0]  host_flags_ff, host_flags_in;
   logic [1:0]  host_turn_ff, host_turn_in;
   logic        host_brake_ff, host_brake_in;
   logic        host_window_ff, host_window_in;
   logic [31:0] host_last_rx_ff, host_last_rx_in;
   logic        host_alive_ff, host_alive_in;
   logic [1:0]  applied_turn_ff, applied_turn_in;
   logic        applied_brake_ff, applied_brake_in;
   logic        turn_from_host_ff, turn_from_host_in;
   logic        brake_from_host_ff, brake_from_host_in;
   logic        applied_window_ff, applied_window_in;
   logic        reply_known_ff, reply_known_in;
   logic        status_pending_ff, status_pending_in;
   logic [31:0] last_status_time_ff, last_status_time_in;

   logic [31:0] host_elapsed, peer_elapsed, status_elapsed;
   logic        hv, pv, trigger, svalid;
   logic        tl_le2, br_le1, wi_le1, tl_le1, rt_le1;
   logic        host_ok, peer_ok;
   logic [2:0]  result;

   assign host_elapsed   = req.now_ms - host_last_rx_ff;
   assign peer_elapsed   = req.now_ms - peer_last_rx_ff;
   assign status_elapsed = req.now_ms - last_status_time_ff;

   assign hv = host_alive_ff && (host_elapsed <= {16'd0, host_timeout_ff});
   assign pv = peer_alive_ff && (peer_elapsed <= {16'd0, peer_timeout_ff});
   assign trigger = status_pending_ff ||
                    (reply_known_ff && (status_elapsed >= {16'd0, status_period_ff}));

   assign tl_le2 = (req.turn_or_left_byte <= 8'd2);
   assign tl_le1 = (req.turn_or_left_byte[7:1] == 7'd0);
   assign rt_le1 = (req.right_byte[7:1] == 7'd0);
   assign br_le1 = (req.brake_byte[7:1] == 7'd0);
   assign wi_le1 = (req.window_byte[7:1] == 7'd0);

   assign host_ok = req.packet_ok &&
                    ((req.mode == lcoa_pkg::MODE_LEGACY) ? (tl_le1 && rt_le1 && br_le1 && wi_le1)
                                                         : (tl_le2 && br_le1 && wi_le1));
   assign peer_ok = req.packet_ok && tl_le2 && br_le1;

   always_comb begin
      peer_turn_in        = peer_turn_ff;
      peer_brake_in       = peer_brake_ff;
      peer_sequence_in    = peer_sequence_ff;
      peer_last_rx_in     = peer_last_rx_ff;
      peer_alive_in       = peer_alive_ff;
      host_flags_in       = host_flags_ff;
      host_turn_in        = host_turn_ff;
      host_brake_in       = host_brake_ff;
      host_window_in      = host_window_ff;
      host_last_rx_in     = host_last_rx_ff;
      host_alive_in       = host_alive_ff;
      applied_turn_in     = applied_turn_ff;
      applied_brake_in    = applied_brake_ff;
      turn_from_host_in   = turn_from_host_ff;
      brake_from_host_in  = brake_from_host_ff;
      applied_window_in   = applied_window_ff;
      reply_known_in      = reply_known_ff;
      status_pending_in   = status_pending_ff;
      last_status_time_in = last_status_time_ff;
      svalid              = 1'b0;
      result              = lcoa_pkg::RES_TICK;

      case (req.mode)
         lcoa_pkg::MODE_FULL, lcoa_pkg::MODE_LEGACY: begin
            result = host_ok ? lcoa_pkg::RES_CMD_OK : lcoa_pkg::RES_CMD_REJ;
            if (host_ok) begin
               if (req.mode == lcoa_pkg::MODE_LEGACY) begin
                  host_flags_in = 3'b111;
                  if (req.turn_or_left_byte[0]) begin
                     host_turn_in = lcoa_pkg::TURN_LEFT;
                  end else if (req.right_byte[0]) begin
                     host_turn_in = lcoa_pkg::TURN_RIGHT;
                  end else begin
                     host_turn_in = lcoa_pkg::TURN_OFF;
                  end
               end else begin
                  host_flags_in = req.override_byte[2:0];
                  host_turn_in  = req.turn_or_left_byte[1:0];
               end
               host_brake_in   = req.brake_byte[0];
               host_window_in  = req.window_byte[0];
               host_last_rx_in = req.now_ms;
               host_alive_in   = 1'b1;
            end
         end
         lcoa_pkg::MODE_PEER: begin
            result = peer_ok ? lcoa_pkg::RES_PEER_OK : lcoa_pkg::RES_PEER_REJ;
            if (peer_ok) begin
               peer_sequence_in  = req.sequence_number;
               peer_turn_in      = req.turn_or_left_byte[1:0];
               peer_brake_in     = req.brake_byte[0];
               peer_last_rx_in   = req.now_ms;
               peer_alive_in     = 1'b1;
               reply_known_in    = 1'b1;
               status_pending_in = 1'b1;
            end
         end
         default: begin
            // tick: watchdogs, then source selection and the status record
            if (!hv) begin
               host_alive_in = 1'b0;
               host_flags_in = 3'b000;
            end
            if (!pv) begin
               peer_alive_in = 1'b0;
            end
            if (hv && host_flags_ff[lcoa_pkg::OVR_TURN_BIT]) begin
               applied_turn_in   = host_turn_ff;
               turn_from_host_in = 1'b1;
            end else begin
               applied_turn_in   = pv ? peer_turn_ff : lcoa_pkg::TURN_OFF;
               turn_from_host_in = 1'b0;
            end
            if (hv && host_flags_ff[lcoa_pkg::OVR_BRAKE_BIT]) begin
               applied_brake_in   = host_brake_ff;
               brake_from_host_in = 1'b1;
            end else begin
               applied_brake_in   = pv & peer_brake_ff;
               brake_from_host_in = 1'b0;
            end
            applied_window_in = hv & host_flags_ff[lcoa_pkg::OVR_WINDOW_BIT] & host_window_ff;
            if (trigger) begin
               status_pending_in   = 1'b0;
               last_status_time_in = req.now_ms;
               svalid              = reply_known_ff;
            end
         end
      endcase
   end

   always_comb begin
      rsp                 = '0;
      rsp.event_result    = result;
      rsp.led_left        = (applied_turn_in == lcoa_pkg::TURN_LEFT);
      rsp.led_right       = (applied_turn_in == lcoa_pkg::TURN_RIGHT);
      rsp.led_brake       = applied_brake_in;
      rsp.window_drive    = applied_window_in;
      rsp.status_valid    = svalid;
      if (svalid) begin
         rsp.status_sequence = peer_sequence_in;
         rsp.status_turn     = applied_turn_in;
         rsp.status_brake    = applied_brake_in;
         rsp.status_sources  = {host_alive_in, brake_from_host_in, turn_from_host_in,
                                peer_alive_in};
         rsp.status_bus_off  = req.bus_off;
         rsp.status_window   = applied_window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_timeout_ff  <= lcoa_pkg::HOST_TIMEOUT_RESET;
         peer_timeout_ff  <= lcoa_pkg::PEER_TIMEOUT_RESET;
         status_period_ff <= lcoa_pkg::STATUS_PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lcoa_pkg::CSR_HOST_TIMEOUT:  host_timeout_ff  <= csr_wdata;
            lcoa_pkg::CSR_PEER_TIMEOUT:  peer_timeout_ff  <= csr_wdata;
            lcoa_pkg::CSR_STATUS_PERIOD: status_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peer_turn_ff        <= '0;
         peer_brake_ff       <= 1'b0;
         peer_sequence_ff    <= '0;
         peer_last_rx_ff     <= '0;
         peer_alive_ff       <= 1'b0;
         host_flags_ff       <= '0;
         host_turn_ff        <= '0;
         host_brake_ff       <= 1'b0;
         host_window_ff      <= 1'b0;
         host_last_rx_ff     <= '0;
         host_alive_ff       <= 1'b0;
         applied_turn_ff     <= '0;
         applied_brake_ff    <= 1'b0;
         turn_from_host_ff   <= 1'b0;
         brake_from_host_ff  <= 1'b0;
         applied_window_ff   <= 1'b0;
         reply_known_ff      <= 1'b0;
         status_pending_ff   <= 1'b0;
         last_status_time_ff <= '0;
      end else if (advance) begin
         peer_turn_ff        <= peer_turn_in;
         peer_brake_ff       <= peer_brake_in;
         peer_sequence_ff    <= peer_sequence_in;
         peer_last_rx_ff     <= peer_last_rx_in;
         peer_alive_ff       <= peer_alive_in;
         host_flags_ff       <= host_flags_in;
         host_turn_ff        <= host_turn_in;
         host_brake_ff       <= host_brake_in;
         host_window_ff      <= host_window_in;
         host_last_rx_ff     <= host_last_rx_in;
         host_alive_ff       <= host_alive_in;
         applied_turn_ff     <= applied_turn_in;
         applied_brake_ff    <= applied_brake_in;
         turn_from_host_ff   <= turn_from_host_in;
         brake_from_host_ff  <= brake_from_host_in;
         applied_window_ff   <= applied_window_in;
         reply_known_ff      <= reply_known_in;
         status_pending_ff   <= status_pending_in;
         last_status_time_ff <= last_status_time_in;
      end
   end

   // override flags only live while the host link is alive
   assert property (@(posedge clock) disable iff (reset)
      (host_flags_ff != 3'b000) |-> host_alive_ff)
      else $error("host override flags set with host link dead");

   assert property (@(posedge clock) disable iff (reset)
      (advance && rsp.event_result == lcoa_pkg::RES_PEER_OK) |=>
      (reply_known_ff && status_pending_ff))
      else $error("accepted peer request did not arm status");

   assert property (@(posedge clock) disable iff (reset)
      rsp.status_valid |-> (req.mode == lcoa_pkg::MODE_TICK && reply_known_ff))
      else $error("status record outside a tick or without reply path");

   assert property (@(posedge clock) disable iff (reset)
      (!reset && !advance) |=> ($stable(applied_turn_ff) && $stable(host_alive_ff) &&
                                $stable(peer_alive_ff)))
      else $error("arbiter state changed without a request");

   assert property (@(posedge clock) disable iff (reset)
      applied_turn_ff != 2'd3)
      else $error("applied turn out of range");

endmodule

### src/lcoa_out_stage.sv
// ----------------------------------------------------------------------------
// lcoa_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module lcoa_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  lcoa_pkg::rsp_type rsp_in,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output lcoa_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   lcoa_pkg::rsp_type data_ff;

   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### src/lamp_command_override_arbiter.sv
// One request per clock cycle while rsp_stall is low. Each request is registered, passes
// one pass of compare-and-select logic that also updates the link state, and lands in a
// result register, where its result is presented, so a new request is taken while the
// previous result waits. Throughput is limited only by the result side: while rsp_stall
// holds, at most one further request is buffered.
// Register writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
// lamp_command_override_arbiter
// Host/peer lamp command arbitration with link watchdogs and status records.
// ----------------------------------------------------------------------------
module lamp_command_override_arbiter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now_ms,
   input  logic        req_packet_ok,
   input  logic [7:0]  req_override_byte,
   input  logic [7:0]  req_turn_or_left_byte,
   input  logic [7:0]  req_right_byte,
   input  logic [7:0]  req_brake_byte,
   input  logic [7:0]  req_window_byte,
   input  logic [15:0] req_sequence_number,
   input  logic        req_bus_off,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_result,
   output logic        rsp_led_left,
   output logic        rsp_led_right,
   output logic        rsp_led_brake,
   output logic        rsp_window_drive,
   output logic        rsp_status_valid,
   output logic [15:0] rsp_status_sequence,
   output logic [1:0]  rsp_status_turn,
   output logic        rsp_status_brake,
   output logic [3:0]  rsp_status_sources,
   output logic        rsp_status_bus_off,
   output logic        rsp_status_window
);

   lcoa_pkg::req_type req_data, held_data;
   lcoa_pkg::rsp_type core_rsp, out_data;
   logic              held_valid;
   logic              advance;

   assign req_data.mode              = req_mode;
   assign req_data.now_ms            = req_now_ms;
   assign req_data.packet_ok         = req_packet_ok;
   assign req_data.override_byte     = req_override_byte;
   assign req_data.turn_or_left_byte = req_turn_or_left_byte;
   assign req_data.right_byte        = req_right_byte;
   assign req_data.brake_byte        = req_brake_byte;
   assign req_data.window_byte       = req_window_byte;
   assign req_data.sequence_number   = req_sequence_number;
   assign req_data.bus_off           = req_bus_off;

   // move the held request into the result register when that slot frees up
   assign advance = held_valid & (~rsp_valid | ~rsp_stall);

   lcoa_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   lcoa_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .req       (held_data),
      .rsp       (core_rsp)
   );

   lcoa_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .rsp_in    (core_rsp),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (out_data)
   );

   assign rsp_event_result    = out_data.event_result;
   assign rsp_led_left        = out_data.led_left;
   assign rsp_led_right       = out_data.led_right;
   assign rsp_led_brake       = out_data.led_brake;
   assign rsp_window_drive    = out_data.window_drive;
   assign rsp_status_valid    = out_data.status_valid;
   assign rsp_status_sequence = out_data.status_sequence;
   assign rsp_status_turn     = out_data.status_turn;
   assign rsp_status_brake    = out_data.status_brake;
   assign rsp_status_sources  = out_data.status_sources;
   assign rsp_status_bus_off  = out_data.status_bus_off;
   assign rsp_status_window   = out_data.status_window;

endmodule

### bench/lamp_command_override_arbiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lamp_command_override_arbiter_tb
// Self-checking bench: drives host commands, peer reports and ticks through the
// valid/stall request channel, predicts every reply with a cycle-free model of
// the arbitration and watchdogs, and compares each reply field by field while
// both sides idle and stall at random under several register settings.
// ----------------------------------------------------------------------------
module lamp_command_override_arbiter_tb;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int PHASE_EVENTS = 140;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTED = 200;

   class lamp_scoreboard;
      lcoa_pkg::rsp_type expected_lamp_states[$];
      int unsigned mismatches;
      int unsigned replies_seen;
      bit [15:0] host_timeout, peer_timeout, status_period;
      bit [1:0] peer_turn, host_turn, turn_out;
      bit peer_brake, peer_up, host_brake, host_window, host_up;
      bit brake_out, turn_host, brake_host, window_out;
      bit reply_known, status_pending;
      bit [15:0] peer_seq;
      bit [31:0] peer_last, host_last, last_status;
      bit [2:0] host_flags;

      function new();
         mismatches = 0;
         replies_seen = 0;
         host_timeout = lcoa_pkg::HOST_TIMEOUT_RESET;
         peer_timeout = lcoa_pkg::PEER_TIMEOUT_RESET;
         status_period = lcoa_pkg::STATUS_PERIOD_RESET;
      endfunction

      function void set_register(logic [1:0] index, logic [15:0] value);
         case (index)
            lcoa_pkg::CSR_HOST_TIMEOUT: host_timeout = value;
            lcoa_pkg::CSR_PEER_TIMEOUT: peer_timeout = value;
            lcoa_pkg::CSR_STATUS_PERIOD: status_period = value;
            default: ;
         endcase
      endfunction

      function int outstanding();
         return expected_lamp_states.size();
      endfunction

      // works out the reply of one accepted request and queues it
      function void predict_lamp_state(lcoa_pkg::req_type r);
         lcoa_pkg::rsp_type o;
         bit hv, pv, send, take;
         bit [31:0] host_age, peer_age, status_age;
         o = '0;
         send = 1'b0;
         take = 1'b0;
         case (r.mode)
            lcoa_pkg::MODE_FULL, lcoa_pkg::MODE_LEGACY: begin
               o.event_result = lcoa_pkg::RES_CMD_REJ;
               if (r.packet_ok && r.mode == lcoa_pkg::MODE_LEGACY) begin
                  if (r.turn_or_left_byte <= 8'd1 && r.right_byte <= 8'd1 &&
                      r.brake_byte <= 8'd1 && r.window_byte <= 8'd1) begin
                     take = 1'b1;
                     host_flags = 3'b111;
                     host_turn = (r.turn_or_left_byte != 0) ? lcoa_pkg::TURN_LEFT :
                                 (r.right_byte != 0) ? lcoa_pkg::TURN_RIGHT :
                                 lcoa_pkg::TURN_OFF;
                  end
               end else if (r.packet_ok) begin
                  if (r.turn_or_left_byte <= lcoa_pkg::TURN_RIGHT &&
                      r.brake_byte <= 8'd1 && r.window_byte <= 8'd1) begin
                     take = 1'b1;
                     host_flags = r.override_byte[2:0];
                     host_turn = r.turn_or_left_byte[1:0];
                  end
               end
               if (take) begin
                  host_brake = r.brake_byte[0];
                  host_window = r.window_byte[0];
                  host_last = r.now_ms;
                  host_up = 1'b1;
                  o.event_result = lcoa_pkg::RES_CMD_OK;
               end
            end
            lcoa_pkg::MODE_PEER: begin
               if (r.packet_ok && r.turn_or_left_byte <= lcoa_pkg::TURN_RIGHT &&
                   r.brake_byte <= 8'd1) begin
                  peer_seq = r.sequence_number;
                  peer_turn = r.turn_or_left_byte[1:0];
                  peer_brake = r.brake_byte[0];
                  peer_last = r.now_ms;
                  peer_up = 1'b1;
                  reply_known = 1'b1;
                  status_pending = 1'b1;
                  o.event_result = lcoa_pkg::RES_PEER_OK;
               end else begin
                  o.event_result = lcoa_pkg::RES_PEER_REJ;
               end
            end
            default: begin
               // ages wrap, so a timestamp that went backwards reads as stale
               host_age = r.now_ms - host_last;
               peer_age = r.now_ms - peer_last;
               hv = host_up && host_age <= {16'd0, host_timeout};
               pv = peer_up && peer_age <= {16'd0, peer_timeout};
               if (!hv) begin
                  host_up = 1'b0;
                  host_flags = '0;
               end
               if (!pv) peer_up = 1'b0;
               if (hv && host_flags[lcoa_pkg::OVR_TURN_BIT]) begin
                  turn_out = host_turn;
                  turn_host = 1'b1;
               end else begin
                  turn_out = pv ? peer_turn : lcoa_pkg::TURN_OFF;
                  turn_host = 1'b0;
               end
               if (hv && host_flags[lcoa_pkg::OVR_BRAKE_BIT]) begin
                  brake_out = host_brake;
                  brake_host = 1'b1;
               end else begin
                  brake_out = pv ? peer_brake : 1'b0;
                  brake_host = 1'b0;
               end
               window_out = (hv && host_flags[lcoa_pkg::OVR_WINDOW_BIT]) ? host_window : 1'b0;
               status_age = r.now_ms - last_status;
               if (status_pending ||
                   (reply_known && status_age >= {16'd0, status_period})) begin
                  status_pending = 1'b0;
                  last_status = r.now_ms;
                  send = reply_known;
               end
               o.event_result = lcoa_pkg::RES_TICK;
            end
         endcase
         o.led_left = (turn_out == lcoa_pkg::TURN_LEFT);
         o.led_right = (turn_out == lcoa_pkg::TURN_RIGHT);
         o.led_brake = brake_out;
         o.window_drive = window_out;
         o.status_valid = send;
         if (send) begin
            o.status_sequence = peer_seq;
            o.status_turn = turn_out;
            o.status_brake = brake_out;
            o.status_sources = {host_up, brake_host, turn_host, peer_up};
            o.status_bus_off = r.bus_off;
            o.status_window = window_out;
         end
         expected_lamp_states.push_back(o);
      endfunction

      task report(string msg);
         if (mismatches < MAX_PRINTED)
            $display("%0t ERROR reply %0d: %s", $time, replies_seen, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s is %0h, should be %0h", name, got, want));
      endtask

      task check_lamp_state(lcoa_pkg::rsp_type got);
         lcoa_pkg::rsp_type want;
         replies_seen++;
         if (expected_lamp_states.size() == 0) begin
            report("reply with no request outstanding");
         end else begin
            want = expected_lamp_states.pop_front();
            compare_field("event_result", got.event_result, want.event_result);
            compare_field("led_left", got.led_left, want.led_left);
            compare_field("led_right", got.led_right, want.led_right);
            compare_field("led_brake", got.led_brake, want.led_brake);
            compare_field("window_drive", got.window_drive, want.window_drive);
            compare_field("status_valid", got.status_valid, want.status_valid);
            compare_field("status_sequence", got.status_sequence, want.status_sequence);
            compare_field("status_turn", got.status_turn, want.status_turn);
            compare_field("status_brake", got.status_brake, want.status_brake);
            compare_field("status_sources", got.status_sources, want.status_sources);
            compare_field("status_bus_off", got.status_bus_off, want.status_bus_off);
            compare_field("status_window", got.status_window, want.status_window);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [31:0] req_now_ms;
   logic        req_packet_ok;
   logic [7:0]  req_override_byte;
   logic [7:0]  req_turn_or_left_byte;
   logic [7:0]  req_right_byte;
   logic [7:0]  req_brake_byte;
   logic [7:0]  req_window_byte;
   logic [15:0] req_sequence_number;
   logic        req_bus_off;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_event_result;
   logic        rsp_led_left;
   logic        rsp_led_right;
   logic        rsp_led_brake;
   logic        rsp_window_drive;
   logic        rsp_status_valid;
   logic [15:0] rsp_status_sequence;
   logic [1:0]  rsp_status_turn;
   logic        rsp_status_brake;
   logic [3:0]  rsp_status_sources;
   logic        rsp_status_bus_off;
   logic        rsp_status_window;

   lamp_scoreboard sb;
   int unsigned cfg_host = lcoa_pkg::HOST_TIMEOUT_RESET;
   int unsigned cfg_peer = lcoa_pkg::PEER_TIMEOUT_RESET;
   int unsigned cfg_period = lcoa_pkg::STATUS_PERIOD_RESET;

   lamp_command_override_arbiter i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin : monitors
      lcoa_pkg::rsp_type seen;
      lcoa_pkg::req_type taken;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.event_result = rsp_event_result;
            seen.led_left = rsp_led_left;
            seen.led_right = rsp_led_right;
            seen.led_brake = rsp_led_brake;
            seen.window_drive = rsp_window_drive;
            seen.status_valid = rsp_status_valid;
            seen.status_sequence = rsp_status_sequence;
            seen.status_turn = rsp_status_turn;
            seen.status_brake = rsp_status_brake;
            seen.status_sources = rsp_status_sources;
            seen.status_bus_off = rsp_status_bus_off;
            seen.status_window = rsp_status_window;
            sb.check_lamp_state(seen);
         end
         if (csr_we) sb.set_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            taken.mode = req_mode;
            taken.now_ms = req_now_ms;
            taken.packet_ok = req_packet_ok;
            taken.override_byte = req_override_byte;
            taken.turn_or_left_byte = req_turn_or_left_byte;
            taken.right_byte = req_right_byte;
            taken.brake_byte = req_brake_byte;
            taken.window_byte = req_window_byte;
            taken.sequence_number = req_sequence_number;
            taken.bus_off = req_bus_off;
            sb.predict_lamp_state(taken);
         end
      end
   end

   // receiver: stretches of free flow, random and periodic stalls, long hold-offs
   initial begin : receiver
      int segment, kind, span, step;
      rsp_stall = 1'b0;
      segment = 0;
      @(posedge clock);
      forever begin
         segment++;
         if (segment % 10 == 4) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            kind = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (step = 0; step < span; step++) begin
               case (kind)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 1) == 1);
                  2: rsp_stall <= (step % 3 == 0);
                  default: rsp_stall <= ($urandom_range(0, 4) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic lcoa_pkg::req_type make_event(logic [1:0] mode, logic [31:0] now,
                                                    logic ok, logic [7:0] ovr,
                                                    logic [7:0] tl, logic [7:0] rt,
                                                    logic [7:0] br, logic [7:0] wi,
                                                    logic [15:0] seq, logic bus);
      lcoa_pkg::req_type r;
      r.mode = mode;
      r.now_ms = now;
      r.packet_ok = ok;
      r.override_byte = ovr;
      r.turn_or_left_byte = tl;
      r.right_byte = rt;
      r.brake_byte = br;
      r.window_byte = wi;
      r.sequence_number = seq;
      r.bus_off = bus;
      return r;
   endfunction

   task automatic offer_request(input lcoa_pkg::req_type r);
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_now_ms <= r.now_ms;
      req_packet_ok <= r.packet_ok;
      req_override_byte <= r.override_byte;
      req_turn_or_left_byte <= r.turn_or_left_byte;
      req_right_byte <= r.right_byte;
      req_brake_byte <= r.brake_byte;
      req_window_byte <= r.window_byte;
      req_sequence_number <= r.sequence_number;
      req_bus_off <= r.bus_off;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic rest_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // the first edge lets the monitor note the last request before the count is read
   task automatic wait_drained();
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned host, input int unsigned peer,
                            input int unsigned period, input logic [31:0] start,
                            input bit poke_spare);
      lcoa_pkg::req_type r;
      logic [31:0] gen_now, host_seen, peer_seen, anchor;
      int unsigned scale;
      int sent, burst, pick, sel;
      if (poke_spare) write_csr(CSR_SPARE, 16'($urandom));
      write_csr(lcoa_pkg::CSR_HOST_TIMEOUT, 16'(host));
      write_csr(lcoa_pkg::CSR_PEER_TIMEOUT, 16'(peer));
      write_csr(lcoa_pkg::CSR_STATUS_PERIOD, 16'(period));
      csr_we <= 1'b0;
      cfg_host = host;
      cfg_peer = peer;
      cfg_period = period;
      gen_now = start;
      host_seen = start;
      peer_seen = start;
      sent = 0;
      while (sent < PHASE_EVENTS) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && sent < PHASE_EVENTS) begin
            pick = $urandom_range(0, 99);
            r.mode = (pick < 40) ? lcoa_pkg::MODE_TICK :
                     (pick < 60) ? lcoa_pkg::MODE_FULL :
                     (pick < 75) ? lcoa_pkg::MODE_LEGACY : lcoa_pkg::MODE_PEER;
            r.packet_ok = ($urandom_range(0, 19) != 0);
            r.override_byte = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
               r.turn_or_left_byte = 8'($urandom);
            else if (r.mode == lcoa_pkg::MODE_LEGACY)
               r.turn_or_left_byte = 8'($urandom_range(0, 1));
            else
               r.turn_or_left_byte = 8'($urandom_range(0, 2));
            if (r.mode == lcoa_pkg::MODE_LEGACY && $urandom_range(0, 9) != 0)
               r.right_byte = 8'($urandom_range(0, 1));
            else
               r.right_byte = 8'($urandom);
            r.brake_byte = ($urandom_range(0, 11) == 0) ? 8'($urandom) :
                           8'($urandom_range(0, 1));
            r.window_byte = ($urandom_range(0, 11) == 0) ? 8'($urandom) :
                            8'($urandom_range(0, 1));
            r.sequence_number = 16'($urandom);
            r.bus_off = ($urandom_range(0, 1) == 1);
            case ($urandom_range(0, 2))
               0: scale = cfg_host;
               1: scale = cfg_peer;
               default: scale = cfg_period;
            endcase
            // timestamps mostly creep forward; ticks often land on a timeout edge
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
            end else if (sel < 55) begin
               gen_now += 32'($urandom_range(0, scale / 8 + 3));
            end else if (sel < 80 && r.mode == lcoa_pkg::MODE_TICK) begin
               anchor = ($urandom_range(0, 1) == 1) ? host_seen : peer_seen;
               gen_now = anchor + 32'(scale) + 32'($urandom_range(0, 2)) - 32'd1;
            end else if (sel < 95) begin
               gen_now += 32'($urandom_range(0, 3 * scale + 10));
            end else begin
               gen_now = $urandom;
            end
            r.now_ms = gen_now;
            if (r.mode == lcoa_pkg::MODE_FULL || r.mode == lcoa_pkg::MODE_LEGACY)
               host_seen = gen_now;
            if (r.mode == lcoa_pkg::MODE_PEER) peer_seen = gen_now;
            offer_request(r);
            sent++;
            burst--;
         end
         if ($urandom_range(0, 3) != 0) rest_sender($urandom_range(1, 8));
      end
      req_valid <= 1'b0;
      wait_drained();
   endtask

   initial begin : stimulus
      int n;
      sb = new();
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_mode = lcoa_pkg::MODE_TICK;
      req_now_ms = '0;
      req_packet_ok = 1'b0;
      req_override_byte = '0;
      req_turn_or_left_byte = '0;
      req_right_byte = '0;
      req_brake_byte = '0;
      req_window_byte = '0;
      req_sequence_number = '0;
      req_bus_off = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // tick straight out of reset: nothing alive, no reply path yet
      offer_request(make_event(lcoa_pkg::MODE_TICK, 32'd1000, 1'b1, 8'h00, 8'h00,
                               8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_FULL, 32'd1000, 1'b1, 8'hFF, 8'd2,
                               8'hFF, 8'd1, 8'd1, 16'hFFFF, 1'b1));
      // host link exactly at its timeout, then one past it
      offer_request(make_event(lcoa_pkg::MODE_TICK, 32'd1500, 1'b0, 8'hA5, 8'hA5,
                               8'hA5, 8'hA5, 8'hA5, 16'h5A5A, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_TICK, 32'd1501, 1'b1, 8'h00, 8'h00,
                               8'h00, 8'h00, 8'h00, 16'h0000, 1'b1));
      offer_request(make_event(lcoa_pkg::MODE_FULL, 32'd1600, 1'b1, 8'h07, 8'd3,
                               8'h00, 8'd0, 8'd0, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_FULL, 32'd1600, 1'b1, 8'h07, 8'd0,
                               8'h00, 8'd2, 8'd0, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_FULL, 32'd1600, 1'b1, 8'h07, 8'd0,
                               8'h00, 8'd0, 8'd2, 16'h0000, 1'b0));
      // bad framing on an otherwise valid command
      offer_request(make_event(lcoa_pkg::MODE_FULL, 32'd1600, 1'b0, 8'h07, 8'd1,
                               8'h00, 8'd1, 8'd1, 16'h0000, 1'b0));
      // legacy form: left wins over right, all overrides forced on
      offer_request(make_event(lcoa_pkg::MODE_LEGACY, 32'd2000, 1'b1, 8'h00, 8'd1,
                               8'd1, 8'd1, 8'd0, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_TICK, 32'd2000, 1'b1, 8'h00, 8'h00,
                               8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_LEGACY, 32'd2001, 1'b1, 8'h00, 8'd0,
                               8'd1, 8'd0, 8'd1, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_LEGACY, 32'd2001, 1'b1, 8'h00, 8'd0,
                               8'd2, 8'd0, 8'd0, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_PEER, 32'd2002, 1'b1, 8'hFF, 8'd2,
                               8'hFF, 8'd1, 8'hFF, 16'hFFFF, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_TICK, 32'd2003, 1'b1, 8'h00, 8'h00,
                               8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_PEER, 32'd2004, 1'b1, 8'h00, 8'd3,
                               8'h00, 8'd0, 8'h00, 16'h1111, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_PEER, 32'd2004, 1'b0, 8'h00, 8'd1,
                               8'h00, 8'd0, 8'h00, 16'h2222, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_PEER, 32'd2004, 1'b1, 8'h00, 8'd1,
                               8'h00, 8'hFF, 8'h00, 16'h3333, 1'b0));
      // high override bits only: host alive but the peer keeps control
      offer_request(make_event(lcoa_pkg::MODE_FULL, 32'd2010, 1'b1, 8'hF8, 8'd1,
                               8'h00, 8'd0, 8'd1, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_TICK, 32'd2050, 1'b1, 8'h00, 8'h00,
                               8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_TICK, 32'd2103, 1'b1, 8'h00, 8'h00,
                               8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      // timestamps wrapping through zero
      offer_request(make_event(lcoa_pkg::MODE_FULL, 32'hFFFF_FFF0, 1'b1, 8'h07, 8'd1,
                               8'h00, 8'd0, 8'd1, 16'h0000, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_PEER, 32'hFFFF_FFF8, 1'b1, 8'h00, 8'd0,
                               8'h00, 8'd1, 8'h00, 16'h1234, 1'b0));
      offer_request(make_event(lcoa_pkg::MODE_TICK, 32'h0000_0010, 1'b1, 8'h00, 8'h00,
                               8'h00, 8'h00, 8'h00, 16'h0000, 1'b1));
      offer_request(make_event(lcoa_pkg::MODE_TICK, 32'h0000_0268, 1'b1, 8'h00, 8'h00,
                               8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      req_valid <= 1'b0;
      wait_drained();

      run_phase(0, 0, 0, 32'h0000_1000, 1'b1);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_0000, 1'b0);
      run_phase(500, 500, 100, $urandom, 1'b0);
      run_phase(1, 16'hFFFF, 1, $urandom, 1'b0);
      run_phase(16'hFFFF, 0, 0, 32'hFFFF_FF00, 1'b0);
      for (n = 0; n < 3; n++)
         run_phase($urandom_range(0, 2000), $urandom_range(0, 2000),
                   $urandom_range(1, 300), $urandom, 1'b0);

      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
